>>> design/flcs_pkg.sv
// ----------------------------------------------------------------------------
// flcs_pkg
// Shared types and constants of the flash LED command sequencer: command
// kinds, chip register addresses, mode bits, run slot layout and the
// descriptor that travels from the front end to the access sequencer.
// ----------------------------------------------------------------------------
package flcs_pkg;

  typedef enum logic [1:0] {
    KindInit  = 2'd0,
    KindOff   = 2'd1,
    KindTorch = 2'd2,
    KindFlash = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] CfgFlashTimeout = 2'd0;
  localparam logic [1:0] CfgTxLimit      = 2'd1;
  localparam logic [1:0] CfgDroop        = 2'd2;

  // Chip register addresses
  localparam logic [4:0] AddrStat1 = 5'h02;
  localparam logic [4:0] AddrStat2 = 5'h03;
  localparam logic [4:0] AddrFl1   = 5'h04;
  localparam logic [4:0] AddrFl2   = 5'h05;
  localparam logic [4:0] AddrTo1   = 5'h06;
  localparam logic [4:0] AddrTo2   = 5'h07;
  localparam logic [4:0] AddrMode  = 5'h08;
  localparam logic [4:0] AddrTx1   = 5'h09;
  localparam logic [4:0] AddrTx2   = 5'h0A;
  localparam logic [4:0] AddrFramp = 5'h0B;
  localparam logic [4:0] AddrTramp = 5'h0C;
  localparam logic [4:0] AddrFtmr  = 5'h0D;
  localparam logic [4:0] AddrTtmr  = 5'h0E;
  localparam logic [4:0] AddrDroop = 5'h10;
  localparam logic [4:0] AddrDc1   = 5'h15;
  localparam logic [4:0] AddrDc2   = 5'h16;
  localparam logic [4:0] AddrIlim  = 5'h17;

  // Register bit fields and fixed bytes
  localparam logic [7:0] ModeTorchBits = 8'h38;
  localparam logic [7:0] ModeFlashBits = 8'h07;
  localparam logic [7:0] ModeStrobe    = 8'h02;
  localparam logic [7:0] ModeIdle      = 8'hC0;
  localparam logic [7:0] EnBit         = 8'h80;
  localparam logic [7:0] TxEnBits      = 8'hC0;
  localparam logic [7:0] Dc1Value      = 8'hC0;
  localparam logic [7:0] Dc2Value      = 8'h8C;
  localparam logic [7:0] IlimValue     = 8'h52;
  localparam logic [5:0] CodeTop       = 6'h3F;

  // Reciprocal constants: exact floors for any 11-bit request
  //   torch steps   = (ma * TorchRecip) >> RecipShift   (ma*1000/3910)
  //   flash steps   = (ma * FlashRecip) >> RecipShift   (ma*1000/15625)
  //   torch applied = (steps * TorchApplied) >> AppliedShift (steps*3.91)
  localparam int unsigned RecipShift   = 20;
  localparam int unsigned AppliedShift = 16;
  localparam logic [18:0] TorchRecip   = 19'd268179;
  localparam logic [16:0] FlashRecip   = 17'd67109;
  localparam logic [17:0] TorchApplied = 18'd256246;
  localparam logic [6:0]  FlashStepMul = 7'd125;   // 15.625 mA = 125/8
  localparam logic [10:0] TorchTopMa   = 11'd250;

  // Run slots: one bit of the enable mask per possible access
  localparam int unsigned NumSlots    = 17;
  localparam int unsigned SlotW       = 5;
  localparam int unsigned SlotStat2   = 0;
  localparam int unsigned SlotStat1   = 1;
  localparam int unsigned SlotModeRd  = 2;
  localparam int unsigned SlotModeClr = 3;
  localparam int unsigned SlotSetA    = 4;
  localparam int unsigned SlotSetB    = 5;
  localparam int unsigned SlotSetC    = 6;

  typedef struct packed {
    logic [6:0] flash_timeout_code;
    logic [5:0] tx_limit_code;
    logic [7:0] droop_setting;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          mode;
    logic [10:0]         applied;
    logic [7:0]          val_a;   // TO1 byte (torch) or FL1 byte (flash)
    logic [7:0]          val_b;   // FL2 byte (flash)
    logic [NumSlots-1:0] mask;    // slots that this run emits
  } desc_t;

endpackage

>>> design/flash_led_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// flash_led_command_sequencer_top
// Turns LED flash driver commands into runs of chip register accesses.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_stall_o  kind_i, req_ma_i, mode_now_i
//   out      out  out_valid_o/ out_stall_i access_write_o, reg_address_o,
//                                          reg_data_o, applied_ma_o, last_o
//   cfg      in   cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// A command runs two front stages, then waits in a QueueDepth-entry queue.
// The sequencer emits one access per cycle while the output is not stalled,
// so a command of n accesses (4 to 17) gives n output beats; back-to-back
// commands flow without gaps. The first access passes stage A, stage B, the queue and the output register.
// Reset clears all valid state and loads the register defaults.
// A stall on the output fills the queue, then raises in_stall_o.
// ----------------------------------------------------------------------------
module flash_led_command_sequencer_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [10:0] req_ma_i,
  input  logic [7:0]  mode_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        access_write_o,
  output logic [4:0]  reg_address_o,
  output logic [7:0]  reg_data_o,
  output logic [10:0] applied_ma_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);
  import flcs_pkg::*;

  cfg_t  cfg_q;
  desc_t front_desc;
  desc_t head_desc;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_timeout_code <= 7'd102;
      cfg_q.tx_limit_code      <= 6'd2;
      cfg_q.droop_setting      <= 8'd51;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFlashTimeout: cfg_q.flash_timeout_code <= cfg_wdata_i[6:0];
        CfgTxLimit:      cfg_q.tx_limit_code      <= cfg_wdata_i[5:0];
        CfgDroop:        cfg_q.droop_setting      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  flcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .req_ma_i     (req_ma_i),
    .mode_now_i   (mode_now_i),
    .push_o       (push),
    .desc_o       (front_desc),
    .full_i       (full)
  );

  flcs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_desc),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_desc)
  );

  flcs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (!empty),
    .desc_i         (head_desc),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .access_write_o (access_write_o),
    .reg_address_o  (reg_address_o),
    .reg_data_o     (reg_data_o),
    .applied_ma_o   (applied_ma_o),
    .last_o         (last_o)
  );

endmodule

>>> design/flcs_front.sv
// ----------------------------------------------------------------------------
// flcs_front
// Command front end: two pipeline stages that turn a request current into
// step codes and the applied current, and build the run descriptor.
// ----------------------------------------------------------------------------
module flcs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [10:0]      req_ma_i,
  input  logic [7:0]       mode_now_i,
  output logic             push_o,
  output flcs_pkg::desc_t  desc_o,
  input  logic             full_i
);
  import flcs_pkg::*;

  // Stage A: reciprocal products
  logic        a_v_q;
  kind_e       a_kind_q;
  logic [7:0]  a_mode_q;
  logic        a_ttop_q;
  logic [29:0] a_pt_q;
  logic [27:0] a_pf_q;

  // Stage B: step counts and torch applied product
  logic        b_v_q;
  kind_e       b_kind_q;
  logic [7:0]  b_mode_q;
  logic        b_ttop_q;
  logic [9:0]  b_q_q;
  logic [7:0]  b_n_q;
  logic [27:0] b_pa_q;

  logic        a_ready;
  logic        b_ready;
  logic [29:0] pt_d;
  logic [27:0] pf_d;
  logic [9:0]  q_d;
  logic [27:0] pa_d;

  logic        torch_low;
  logic [5:0]  torch_code;
  logic [7:0]  torch_byte;
  logic [6:0]  n1;
  logic [7:0]  n2;
  logic [13:0] fl_prod;

  function automatic logic [7:0] flash_byte(input logic [7:0] n);
    logic [5:0] code;
    code = (n >= 8'd64) ? CodeTop : 6'(n - 8'd1);
    return (n == 8'd0) ? 8'h00 : (EnBit | {2'b00, code});
  endfunction

  assign b_ready    = !b_v_q || !full_i;
  assign a_ready    = !a_v_q || b_ready;
  assign in_stall_o = !a_ready;
  assign push_o     = b_v_q && !full_i;

  assign pt_d = 30'(req_ma_i) * 30'(TorchRecip);
  assign pf_d = 28'(req_ma_i) * 28'(FlashRecip);
  assign q_d  = a_pt_q[29:20];
  assign pa_d = 28'(q_d) * 28'(TorchApplied);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= in_valid_i;
      end
      if (b_ready) begin
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_kind_q <= kind_e'(kind_i);
      a_mode_q <= mode_now_i;
      a_ttop_q <= req_ma_i >= TorchTopMa;
      a_pt_q   <= pt_d;
      a_pf_q   <= pf_d;
    end
    if (a_v_q && b_ready) begin
      b_kind_q <= a_kind_q;
      b_mode_q <= a_mode_q;
      b_ttop_q <= a_ttop_q;
      b_q_q    <= q_d;
      b_n_q    <= a_pf_q[27:20];
      b_pa_q   <= pa_d;
    end
  end

  assign torch_low  = (b_q_q == 10'd0);
  assign torch_code = b_ttop_q ? CodeTop : 6'(b_q_q - 10'd1);
  assign torch_byte = EnBit | {1'b0, torch_code, 1'b0};
  // channel 1 takes half the steps rounded down, channel 2 the rest
  assign n1         = b_n_q[7:1];
  assign n2         = b_n_q - {1'b0, n1};
  assign fl_prod    = 14'(b_n_q) * 14'(FlashStepMul);

  always_comb begin
    desc_o         = '0;
    desc_o.kind    = b_kind_q;
    desc_o.mode    = b_mode_q;
    case (b_kind_q)
      KindInit: begin
        desc_o.mask = '1;
      end
      KindOff: begin
        desc_o.mask = {{(NumSlots-4){1'b0}}, 4'hF};
      end
      KindTorch: begin
        desc_o.applied             = b_pa_q[26:16];
        desc_o.val_a               = torch_low ? 8'h00 : torch_byte;
        desc_o.mask[SlotStat2]     = 1'b1;
        desc_o.mask[SlotStat1]     = 1'b1;
        desc_o.mask[SlotModeRd]    = 1'b1;
        desc_o.mask[SlotModeClr]   = torch_low || ((b_mode_q & ModeTorchBits) != 8'h00);
        desc_o.mask[SlotSetA]      = 1'b1;
        desc_o.mask[SlotSetB]      = !torch_low;
      end
      KindFlash: begin
        desc_o.applied             = fl_prod[13:3];
        desc_o.val_a               = flash_byte({1'b0, n1});
        desc_o.val_b               = flash_byte(n2);
        desc_o.mask[SlotStat2]     = 1'b1;
        desc_o.mask[SlotStat1]     = 1'b1;
        desc_o.mask[SlotModeRd]    = 1'b1;
        desc_o.mask[SlotModeClr]   = (b_mode_q & ModeFlashBits) != 8'h00;
        desc_o.mask[SlotSetA]      = 1'b1;
        desc_o.mask[SlotSetB]      = 1'b1;
        desc_o.mask[SlotSetC]      = n2 != 8'd0;
      end
      default: begin
        desc_o.mask = '1;
      end
    endcase
  end

endmodule

>>> design/flcs_fifo.sv
// ----------------------------------------------------------------------------
// flcs_fifo
// Short descriptor queue between the front end and the access sequencer.
// ----------------------------------------------------------------------------
module flcs_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  flcs_pkg::desc_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output flcs_pkg::desc_t data_o
);
  import flcs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> design/flcs_back.sv
// ----------------------------------------------------------------------------
// flcs_back
// Access sequencer: walks the enabled slots of the head descriptor and
// emits one register access per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module flcs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  flcs_pkg::desc_t desc_i,
  output logic            pop_o,
  input  flcs_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            access_write_o,
  output logic [4:0]      reg_address_o,
  output logic [7:0]      reg_data_o,
  output logic [10:0]     applied_ma_o,
  output logic            last_o
);
  import flcs_pkg::*;

  logic [SlotW-1:0] slot_q;
  logic [SlotW-1:0] slot_nxt;
  logic             found;
  logic             adv;
  logic             load;

  logic             out_valid_q;
  logic             acc_write_q;
  logic [4:0]       acc_addr_q;
  logic [7:0]       acc_data_q;
  logic [10:0]      applied_q;
  logic             last_q;

  logic             acc_write;
  logic [4:0]       acc_addr;
  logic [7:0]       acc_data;
  logic [7:0]       mode_base;

  assign mode_base = desc_i.mode & ~(ModeTorchBits | ModeFlashBits);

  // Next enabled slot above the current one
  always_comb begin
    slot_nxt = slot_q;
    found    = 1'b0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if ((SlotW'(i) > slot_q) && desc_i.mask[i]) begin
        slot_nxt = SlotW'(i);
        found    = 1'b1;
      end
    end
  end

  always_comb begin
    acc_write = 1'b1;
    acc_addr  = AddrMode;
    acc_data  = 8'h00;
    case (desc_i.kind)
      KindOff: begin
        case (slot_q)
          5'd0:    begin acc_addr = AddrMode; acc_data = ModeIdle; end
          5'd1:    acc_addr = AddrFl1;
          5'd2:    acc_addr = AddrFl2;
          default: acc_addr = AddrTo1;
        endcase
      end
      KindInit: begin
        case (slot_q)
          5'd0:    begin acc_write = 1'b0; acc_addr = AddrStat2; end
          5'd1:    begin acc_write = 1'b0; acc_addr = AddrStat1; end
          5'd2:    begin acc_addr = AddrMode; acc_data = ModeIdle; end
          5'd3:    acc_addr = AddrFl1;
          5'd4:    acc_addr = AddrTo1;
          5'd5:    acc_addr = AddrFl2;
          5'd6:    acc_addr = AddrTo2;
          5'd7:    acc_addr = AddrTx2;
          5'd8:    acc_addr = AddrFramp;
          5'd9:    acc_addr = AddrTramp;
          5'd10: begin
            acc_addr = AddrTx1;
            acc_data = TxEnBits | {2'b00, cfg_i.tx_limit_code};
          end
          5'd11: begin
            acc_addr = AddrFtmr;
            acc_data = EnBit | {1'b0, cfg_i.flash_timeout_code};
          end
          5'd12:   begin acc_addr = AddrTtmr; acc_data = EnBit; end
          5'd13:   begin acc_addr = AddrDroop; acc_data = cfg_i.droop_setting; end
          5'd14:   begin acc_addr = AddrDc1; acc_data = Dc1Value; end
          5'd15:   begin acc_addr = AddrDc2; acc_data = Dc2Value; end
          default: begin acc_addr = AddrIlim; acc_data = IlimValue; end
        endcase
      end
      default: begin
        // torch and flash share the status reads and the mode read-back
        case (slot_q)
          SlotW'(SlotStat2):  begin acc_write = 1'b0; acc_addr = AddrStat2; end
          SlotW'(SlotStat1):  begin acc_write = 1'b0; acc_addr = AddrStat1; end
          SlotW'(SlotModeRd): begin acc_write = 1'b0; acc_addr = AddrMode; end
          SlotW'(SlotModeClr): begin
            acc_addr = AddrMode;
            acc_data = (desc_i.kind == KindTorch) ? (desc_i.mode & ~ModeTorchBits)
                                                  : (desc_i.mode & ~ModeFlashBits);
          end
          SlotW'(SlotSetA): begin
            acc_addr = (desc_i.kind == KindTorch) ? AddrTo1 : AddrFl1;
            acc_data = desc_i.val_a;
          end
          SlotW'(SlotSetB): begin
            if (desc_i.kind == KindTorch) begin
              acc_addr = AddrMode;
              acc_data = mode_base | ModeTorchBits;
            end else begin
              acc_addr = AddrFl2;
              acc_data = desc_i.val_b;
            end
          end
          default: begin
            acc_addr = AddrMode;
            acc_data = mode_base | ModeStrobe;
          end
        endcase
      end
    endcase
  end

  assign adv   = !out_valid_q || !out_stall_i;
  assign load  = adv && head_valid_i;
  assign pop_o = load && !found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= head_valid_i;
      end
      if (load) begin
        slot_q <= found ? slot_nxt : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_write_q <= acc_write;
      acc_addr_q  <= acc_addr;
      acc_data_q  <= acc_data;
      applied_q   <= desc_i.applied;
      last_q      <= !found;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign access_write_o = acc_write_q;
  assign reg_address_o  = acc_addr_q;
  assign reg_data_o     = acc_data_q;
  assign applied_ma_o   = applied_q;
  assign last_o         = last_q;

  a_slot_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> desc_i.mask[slot_q])
    else $error("sequencer sits on a disabled slot");

  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (slot_q == '0))
    else $error("slot not rewound with empty queue");

  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && found) |=> (head_valid_i && (slot_q != '0)))
    else $error("run dropped before its last beat");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the flash LED command sequencer against its own access planner.
// Each accepted command is expanded into the register accesses it must
// produce, and every output beat is compared with the oldest of them. The
// tests cover the reset settings, torch and flash current edges, register
// settings at their extremes, and random traffic with bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
module tb;
  import flcs_pkg::*;

  typedef struct packed {
    logic        write;
    logic [4:0]  addr;
    logic [7:0]  data;
    logic [10:0] applied;
    logic        last;
  } access_t;

  localparam logic [1:0] CfgSpare = 2'd3;  // index with no register behind it
  localparam int unsigned TorchStepUa = 3910;
  localparam int unsigned TorchTopUa = 250000;
  localparam int unsigned FlashStepUa = 15625;
  localparam int unsigned FlashTopUa = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  kind_e       kind = KindInit;
  logic [10:0] req_ma = '0;
  logic [7:0]  mode_now = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        access_write;
  logic [4:0]  reg_address;
  logic [7:0]  reg_data;
  logic [10:0] applied_ma;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CfgFlashTimeout;
  logic [7:0]  cfg_wdata = '0;

  // Register shadow used by the planner
  logic [6:0] timeout_code = 7'd102;
  logic [5:0] tx_code = 6'd2;
  logic [7:0] droop_byte = 8'd51;

  access_t due_accesses[$];
  access_t run_buf[$];
  access_t want, seen;

  int errors = 0;
  int checked = 0;
  int settings = 1;
  int kind_count[4];
  int burst_left = 0;
  int stall_style = 0;
  int stall_hold = 0;

  flash_led_command_sequencer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .req_ma_i       (req_ma),
    .mode_now_i     (mode_now),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .access_write_o (access_write),
    .reg_address_o  (reg_address),
    .reg_data_o     (reg_data),
    .applied_ma_o   (applied_ma),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Access planner
  // ---------------------------------------------------------------------------
  function automatic void add_access(input logic wr, input logic [4:0] addr,
                                     input logic [7:0] data);
    run_buf.push_back('{wr, addr, data, 11'd0, 1'b0});
  endfunction

  function automatic logic [7:0] flash_code(input int unsigned ua);
    if (ua >= FlashTopUa) return {2'b00, CodeTop};
    return 8'(ua / FlashStepUa - 1);
  endfunction

  function automatic void plan_accesses(input kind_e k, input logic [10:0] ma,
                                        input logic [7:0] mode);
    int unsigned ua;
    int unsigned applied;
    int unsigned f1;
    int unsigned f2;
    int unsigned code;
    access_t a;
    ua = ma * 32'd1000;
    applied = 0;
    run_buf.delete();
    if (k == KindOff) begin
      add_access(1'b1, AddrMode, ModeIdle);
      add_access(1'b1, AddrFl1, 8'h00);
      add_access(1'b1, AddrFl2, 8'h00);
      add_access(1'b1, AddrTo1, 8'h00);
    end else begin
      // status reads clear latched faults
      add_access(1'b0, AddrStat2, 8'h00);
      add_access(1'b0, AddrStat1, 8'h00);
      if (k == KindInit) begin
        add_access(1'b1, AddrMode, ModeIdle);
        add_access(1'b1, AddrFl1, 8'h00);
        add_access(1'b1, AddrTo1, 8'h00);
        add_access(1'b1, AddrFl2, 8'h00);
        add_access(1'b1, AddrTo2, 8'h00);
        add_access(1'b1, AddrTx2, 8'h00);
        add_access(1'b1, AddrFramp, 8'h00);
        add_access(1'b1, AddrTramp, 8'h00);
        add_access(1'b1, AddrTx1, TxEnBits | {2'b00, tx_code});
        add_access(1'b1, AddrFtmr, EnBit | {1'b0, timeout_code});
        add_access(1'b1, AddrTtmr, EnBit);
        add_access(1'b1, AddrDroop, droop_byte);
        add_access(1'b1, AddrDc1, Dc1Value);
        add_access(1'b1, AddrDc2, Dc2Value);
        add_access(1'b1, AddrIlim, IlimValue);
      end else if (k == KindTorch) begin
        add_access(1'b0, AddrMode, 8'h00);
        if (ua < TorchStepUa) begin
          add_access(1'b1, AddrMode, mode & ~ModeTorchBits);
          add_access(1'b1, AddrTo1, 8'h00);
        end else begin
          code = (ua >= TorchTopUa) ? 63 : ua / TorchStepUa - 1;
          if ((mode & ModeTorchBits) != 8'h00)
            add_access(1'b1, AddrMode, mode & ~ModeTorchBits);
          add_access(1'b1, AddrTo1, EnBit | 8'(code * 2));
          add_access(1'b1, AddrMode,
                     (mode & ~(ModeTorchBits | ModeFlashBits)) | ModeTorchBits);
        end
        applied = (ua / TorchStepUa) * TorchStepUa / 1000;
      end else begin
        // channel 1 takes half rounded down to a step, channel 2 the rest
        f1 = ((ua / 2) / FlashStepUa) * FlashStepUa;
        f2 = ua - f1;
        add_access(1'b0, AddrMode, 8'h00);
        if ((mode & ModeFlashBits) != 8'h00)
          add_access(1'b1, AddrMode, mode & ~ModeFlashBits);
        add_access(1'b1, AddrFl1, (f1 < FlashStepUa) ? 8'h00 : (EnBit | flash_code(f1)));
        if (f2 < FlashStepUa) begin
          add_access(1'b1, AddrFl2, 8'h00);
        end else begin
          add_access(1'b1, AddrFl2, EnBit | flash_code(f2));
          add_access(1'b1, AddrMode,
                     (mode & ~(ModeTorchBits | ModeFlashBits)) | ModeStrobe);
        end
        applied = (f1 + (f2 / FlashStepUa) * FlashStepUa) / 1000;
      end
    end
    for (int i = 0; i < run_buf.size(); i++) begin
      a = run_buf[i];
      a.applied = 11'(applied);
      a.last = (i == run_buf.size() - 1);
      due_accesses.push_back(a);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_command(input kind_e k, input logic [10:0] ma,
                              input logic [7:0] mode);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    kind <= k;
    req_ma <= ma;
    mode_now <= mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    kind_count[k]++;
    plan_accesses(k, ma, mode);
  endtask

  // Drop valid and wait until every planned access has come out
  task automatic drain_runs();
    in_valid <= 1'b0;
    while (due_accesses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgFlashTimeout: timeout_code = value[6:0];
      CfgTxLimit:      tx_code = value[5:0];
      CfgDroop:        droop_byte = value;
      default: ;
    endcase
  endtask

  task automatic write_setting(input logic [7:0] t, input logic [7:0] x,
                               input logic [7:0] d);
    write_reg(CfgFlashTimeout, t);
    write_reg(CfgTxLimit, x);
    write_reg(CfgDroop, d);
    settings++;
  endtask

  task automatic send_random_command();
    kind_e       k;
    logic [10:0] ma;
    logic [7:0]  mode;
    int          pick;
    pick = $urandom_range(0, 9);
    k = (pick == 0) ? KindInit : (pick == 1) ? KindOff : (pick < 6) ? KindTorch : KindFlash;
    case ($urandom_range(0, 4))
      0:       ma = 11'($urandom_range(0, 40));
      1:       ma = 11'($urandom_range(240, 262));
      2:       ma = 11'($urandom_range(1980, 2047));
      default: ma = 11'($urandom_range(0, 2047));
    endcase
    case ($urandom_range(0, 3))
      0:       mode = 8'h00;
      1:       mode = 8'($urandom) & ~ModeTorchBits;
      2:       mode = 8'($urandom) & ~ModeFlashBits;
      default: mode = 8'($urandom);
    endcase
    send_command(k, ma, mode);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and beat checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_style = $urandom_range(0, 4);
      stall_hold = $urandom_range(8, 60);
    end else begin
      stall_hold--;
    end
    case (stall_style)
      0, 1:    out_stall <= 1'b0;
      2:       out_stall <= ($urandom_range(0, 3) == 0);
      3:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{access_write, reg_address, reg_data, applied_ma, last};
      if (due_accesses.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%t unexpected beat: wr %0d addr %h data %h applied %0d last %0d",
                   $realtime, seen.write, seen.addr, seen.data, seen.applied, seen.last);
      end else begin
        want = due_accesses.pop_front();
        checked++;
        if (seen !== want) begin
          errors++;
          if (errors <= 10)
            $display({"%t mismatch: expected wr %0d addr %h data %h applied %0d last %0d,",
                      " got wr %0d addr %h data %h applied %0d last %0d"}, $realtime,
                     want.write, want.addr, want.data, want.applied, want.last,
                     seen.write, seen.addr, seen.data, seen.applied, seen.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_command(KindInit, 11'd0, 8'h00);
    send_command(KindOff, 11'd2047, 8'hFF);
    drain_runs();
  endtask

  task automatic test_torch_edges();
    send_command(KindTorch, 11'd0, 8'hFF);     // below one step
    send_command(KindTorch, 11'd3, 8'h38);
    send_command(KindTorch, 11'd4, 8'h00);     // lowest code, no clear
    send_command(KindTorch, 11'd249, 8'h3F);
    send_command(KindTorch, 11'd250, 8'hC7);   // saturates
    send_command(KindTorch, 11'd1000, 8'h00);
    send_command(KindTorch, 11'd2047, 8'hFF);
    drain_runs();
  endtask

  task automatic test_flash_edges();
    send_command(KindFlash, 11'd0, 8'h00);     // both channels off
    send_command(KindFlash, 11'd15, 8'h07);
    send_command(KindFlash, 11'd16, 8'h00);    // channel 2 alone
    send_command(KindFlash, 11'd32, 8'hFF);
    send_command(KindFlash, 11'd500, 8'h38);
    send_command(KindFlash, 11'd1990, 8'h05);
    send_command(KindFlash, 11'd2000, 8'h00);  // both saturate
    send_command(KindFlash, 11'd2047, 8'hFF);
    drain_runs();
  endtask

  task automatic test_register_settings();
    write_setting(8'h00, 8'h00, 8'h00);
    write_reg(CfgSpare, 8'hFF);
    send_command(KindInit, 11'd2047, 8'hFF);
    drain_runs();
    write_setting(8'hFF, 8'hFF, 8'hFF);
    send_command(KindInit, 11'd0, 8'h00);
    send_command(KindOff, 11'd0, 8'h00);
    drain_runs();
    write_setting(8'($urandom), 8'($urandom), 8'($urandom));
    send_command(KindInit, 11'($urandom_range(0, 2047)), 8'($urandom));
    drain_runs();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      drain_runs();
      case (phase)
        0:       write_setting(8'($urandom), 8'($urandom), 8'($urandom));
        1:       write_setting(8'h00, 8'h00, 8'h00);
        2:       write_setting(8'h7F, 8'h3F, 8'hFF);
        default: write_setting(8'd102, 8'd2, 8'd51);
      endcase
      send_command(KindInit, 11'($urandom_range(0, 2047)), 8'($urandom));
      repeat (24) send_random_command();
    end
    drain_runs();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_torch_edges();
    test_flash_edges();
    test_register_settings();
    test_random_traffic();
    errors += due_accesses.size();
    $display("Checked %0d register accesses from %0d init, %0d off,",
             checked, kind_count[KindInit], kind_count[KindOff]);
    $display("%0d torch, %0d flash commands over %0d register settings, %0d mismatches",
             kind_count[KindTorch], kind_count[KindFlash], settings, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
